FILE: hdl/lpp_pkg.sv
`default_nettype none
package lpp_pkg;

  localparam int unsigned ROWS_DEF    = 128;
  localparam int unsigned COLUMNS_DEF = 2048;

  localparam int unsigned ROW_W   = 7;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned RANGE_W = 20;
  localparam int unsigned DIR_W   = 18;
  localparam int unsigned OFF_W   = 24;
  localparam int unsigned POS_W   = 26;
  localparam int unsigned NCOL_W  = 12;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 20'd1;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 20'd1000000;
  localparam logic [NCOL_W-1:0]  NCOL_RST      = 12'd1024;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_POINT    = 2'd0,
    ST_EXCLUDED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_FRAME    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_RANGE = 2'd0,
    REG_MAX_RANGE = 2'd1,
    REG_COLUMNS   = 2'd2
  } reg_e;

  typedef struct packed {
    logic                    exclude;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/lpp_table.sv
`default_nettype none
module lpp_table #(
  parameter int unsigned DEPTH = lpp_pkg::ROWS_DEF * lpp_pkg::COLUMNS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   addr_i,
  input  wire lpp_pkg::entry_t wr_data_i,
  output lpp_pkg::entry_t      rd_data_o
);

  // three stores, no reset: entries are undefined until loaded
  logic [3*lpp_pkg::DIR_W:0]   direction_store [DEPTH];
  logic [2*lpp_pkg::OFF_W-1:0] offset_xy_store [DEPTH];
  logic [lpp_pkg::OFF_W-1:0]   offset_z_store  [DEPTH];

  logic [3*lpp_pkg::DIR_W:0]   dir_q;
  logic [2*lpp_pkg::OFF_W-1:0] oxy_q;
  logic [lpp_pkg::OFF_W-1:0]   oz_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      direction_store[addr_i] <= {wr_data_i.exclude, wr_data_i.dir_z,
                                  wr_data_i.dir_y, wr_data_i.dir_x};
      offset_xy_store[addr_i] <= {wr_data_i.off_y, wr_data_i.off_x};
      offset_z_store[addr_i]  <= wr_data_i.off_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      dir_q <= direction_store[addr_i];
      oxy_q <= offset_xy_store[addr_i];
      oz_q  <= offset_z_store[addr_i];
    end
  end

  always_comb begin
    rd_data_o.exclude = dir_q[3*lpp_pkg::DIR_W];
    rd_data_o.dir_z   = dir_q[3*lpp_pkg::DIR_W-1:2*lpp_pkg::DIR_W];
    rd_data_o.dir_y   = dir_q[2*lpp_pkg::DIR_W-1:lpp_pkg::DIR_W];
    rd_data_o.dir_x   = dir_q[lpp_pkg::DIR_W-1:0];
    rd_data_o.off_y   = oxy_q[2*lpp_pkg::OFF_W-1:lpp_pkg::OFF_W];
    rd_data_o.off_x   = oxy_q[lpp_pkg::OFF_W-1:0];
    rd_data_o.off_z   = oz_q;
  end

endmodule
`default_nettype wire

FILE: hdl/lpp_axis.sv
`default_nettype none
module lpp_axis (
  input  wire logic                              clk_i,
  input  wire logic                              mul_en_i,
  input  wire logic                              sum_en_i,
  input  wire logic signed [lpp_pkg::DIR_W-1:0]  dir_i,
  input  wire logic [lpp_pkg::RANGE_W-1:0]       range_i,
  input  wire logic signed [lpp_pkg::OFF_W-1:0]  off_i,
  output logic signed [lpp_pkg::POS_W-1:0]       pos_o
);

  localparam int unsigned PW = lpp_pkg::DIR_W + lpp_pkg::RANGE_W + 1;
  localparam int unsigned SW = PW - 13 + 1;

  localparam logic signed [SW-1:0] PosMax = SW'(33554431);
  localparam logic signed [SW-1:0] PosMin = -SW'(33554432);

  logic signed [lpp_pkg::RANGE_W:0] rng_s;
  logic signed [PW-1:0]             prod_d, prod_q;
  logic signed [lpp_pkg::OFF_W-1:0] off_q;
  logic signed [PW:0]               rnd;
  logic signed [PW-13:0]            shr;
  logic signed [SW-1:0]             sum;
  logic signed [lpp_pkg::POS_W-1:0] pos_d, pos_q;

  assign rng_s  = $signed({1'b0, range_i});
  assign prod_d = PW'(dir_i) * PW'(rng_s);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      off_q  <= off_i;
    end
  end

  // round half up to 1/16 mm: add 2^12, floor shift by 13
  assign rnd = (PW+1)'(prod_q) + (PW+1)'(4096);
  assign shr = rnd[PW:13];
  assign sum = SW'(shr) + SW'(off_q);

  always_comb begin
    if (sum > PosMax) begin
      pos_d = PosMax[lpp_pkg::POS_W-1:0];
    end else if (sum < PosMin) begin
      pos_d = PosMin[lpp_pkg::POS_W-1:0];
    end else begin
      pos_d = sum[lpp_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule
`default_nettype wire

FILE: hdl/lidar_pixel_to_point_projection_top.sv
// Lidar pixel to point projection. Each transaction is a table load (op 0) or a pixel
// conversion (op 1); one is accepted every clock while the output side keeps up, and a
// conversion's point passes through five register stages: input register, index multiply,
// table read, range multiply, round/offset/saturate. Loads give no result. The table is a
// single-port memory of ROWS*COLUMNS entries with a registered read, indexed by row *
// min(columns_in_use, COLUMNS) + column; one access per transaction sets the rate.
// Entries have no reset and are undefined until loaded; there is no clearing pass.
// Stalls fill bubbles first, so new transactions enter while a result waits.
// Registers (APB, 32-bit): 0x0 minimum range (mm), 0x4 maximum range (mm),
// 0x8 columns_in_use.
`default_nettype none
module lidar_pixel_to_point_projection_top #(
  parameter int unsigned ROWS    = lpp_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = lpp_pkg::COLUMNS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpp_pkg::APB_AW-1:0]         paddr,
  input  wire logic [lpp_pkg::APB_DW-1:0]         pwdata,
  output logic [lpp_pkg::APB_DW-1:0]              prdata,
  output logic                                    pready,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic [lpp_pkg::ROW_W-1:0]          row_i,
  input  wire logic [lpp_pkg::COL_W-1:0]          column_i,
  input  wire logic [lpp_pkg::RANGE_W-1:0]        dist_mm_i,
  input  wire logic signed [lpp_pkg::DIR_W-1:0]   dir_x_i,
  input  wire logic signed [lpp_pkg::DIR_W-1:0]   dir_y_i,
  input  wire logic signed [lpp_pkg::DIR_W-1:0]   dir_z_i,
  input  wire logic signed [lpp_pkg::OFF_W-1:0]   off_x_i,
  input  wire logic signed [lpp_pkg::OFF_W-1:0]   off_y_i,
  input  wire logic signed [lpp_pkg::OFF_W-1:0]   off_z_i,
  input  wire logic                               exclude_mark_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic signed [lpp_pkg::POS_W-1:0]        x_pos_o,
  output logic signed [lpp_pkg::POS_W-1:0]        y_pos_o,
  output logic signed [lpp_pkg::POS_W-1:0]        z_pos_o,
  output logic [lpp_pkg::RANGE_W-1:0]             range_echo_o,
  output logic [lpp_pkg::ROW_W-1:0]               row_echo_o,
  output logic [lpp_pkg::COL_W-1:0]               column_echo_o
);

  localparam int unsigned DEPTH = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = lpp_pkg::ROW_W + lpp_pkg::NCOL_W;

  localparam logic [lpp_pkg::ROW_W:0]    RowLimit = (lpp_pkg::ROW_W+1)'(ROWS);
  localparam logic [lpp_pkg::NCOL_W-1:0] ColLimit = lpp_pkg::NCOL_W'(COLUMNS);

  // ---------------- configuration ----------------
  logic [lpp_pkg::RANGE_W-1:0] min_range_q, max_range_q;
  logic [lpp_pkg::NCOL_W-1:0]  ncol_q;
  logic                        cfg_wr;
  logic [lpp_pkg::NCOL_W-1:0]  cols_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= lpp_pkg::MIN_RANGE_RST;
      max_range_q <= lpp_pkg::MAX_RANGE_RST;
      ncol_q      <= lpp_pkg::NCOL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lpp_pkg::REG_MIN_RANGE: min_range_q <= pwdata[lpp_pkg::RANGE_W-1:0];
        lpp_pkg::REG_MAX_RANGE: max_range_q <= pwdata[lpp_pkg::RANGE_W-1:0];
        lpp_pkg::REG_COLUMNS:   ncol_q      <= pwdata[lpp_pkg::NCOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lpp_pkg::REG_MIN_RANGE: prdata = lpp_pkg::APB_DW'(min_range_q);
      lpp_pkg::REG_MAX_RANGE: prdata = lpp_pkg::APB_DW'(max_range_q);
      lpp_pkg::REG_COLUMNS:   prdata = lpp_pkg::APB_DW'(ncol_q);
      default:                prdata = '0;
    endcase
  end

  assign cols_eff = (ncol_q > ColLimit) ? ColLimit : ncol_q;

  // ---------------- pipeline control ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v5_q;

  // ---------------- stage 1: input register ----------------
  logic                        op1_q;
  logic [lpp_pkg::ROW_W-1:0]   row1_q;
  logic [lpp_pkg::COL_W-1:0]   col1_q;
  logic [lpp_pkg::RANGE_W-1:0] rng1_q;
  lpp_pkg::entry_t             ent1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q          <= op_i;
      row1_q         <= row_i;
      col1_q         <= column_i;
      rng1_q         <= dist_mm_i;
      ent1_q.exclude <= exclude_mark_i;
      ent1_q.dir_x   <= dir_x_i;
      ent1_q.dir_y   <= dir_y_i;
      ent1_q.dir_z   <= dir_z_i;
      ent1_q.off_x   <= off_x_i;
      ent1_q.off_y   <= off_y_i;
      ent1_q.off_z   <= off_z_i;
    end
  end

  // ---------------- stage 2: table index ----------------
  logic [LW-1:0]               lin;
  logic                        inside_d;
  logic                        op2_q, inside2_q, rok2_d;
  logic [AW-1:0]               idx2_q;
  logic [lpp_pkg::ROW_W-1:0]   row2_q;
  logic [lpp_pkg::COL_W-1:0]   col2_q;
  logic [lpp_pkg::RANGE_W-1:0] rng2_q;
  lpp_pkg::entry_t             ent2_q;

  assign inside_d = ({1'b0, row1_q} < RowLimit) &&
                    (lpp_pkg::NCOL_W'(col1_q) < cols_eff);
  assign lin      = LW'(row1_q) * LW'(cols_eff) + LW'(col1_q);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q     <= op1_q;
      inside2_q <= inside_d;
      idx2_q    <= lin[AW-1:0];
      row2_q    <= row1_q;
      col2_q    <= col1_q;
      rng2_q    <= rng1_q;
      ent2_q    <= ent1_q;
    end
  end

  // ---------------- stage 3: table access ----------------
  logic                        tbl_wr, tbl_rd;
  lpp_pkg::entry_t             rd_ent;
  logic                        inside3_q, rok3_q;
  logic [lpp_pkg::ROW_W-1:0]   row3_q;
  logic [lpp_pkg::COL_W-1:0]   col3_q;
  logic [lpp_pkg::RANGE_W-1:0] rng3_q;

  assign tbl_wr = en3 && v2_q && (op2_q == lpp_pkg::OP_LOAD) && inside2_q;
  assign tbl_rd = en3 && v2_q && (op2_q == lpp_pkg::OP_CONVERT);
  assign rok2_d = (rng2_q >= min_range_q) && (rng2_q <= max_range_q);

  lpp_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr),
    .rd_en_i   (tbl_rd),
    .addr_i    (idx2_q),
    .wr_data_i (ent2_q),
    .rd_data_o (rd_ent)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      inside3_q <= inside2_q;
      rok3_q    <= rok2_d;
      row3_q    <= row2_q;
      col3_q    <= col2_q;
      rng3_q    <= rng2_q;
    end
  end

  // ---------------- stage 4: status, products ----------------
  lpp_pkg::status_e            st_d, st4_q, st5_q;
  logic [lpp_pkg::ROW_W-1:0]   row4_q, row5_q;
  logic [lpp_pkg::COL_W-1:0]   col4_q, col5_q;
  logic [lpp_pkg::RANGE_W-1:0] rng4_q, rng5_q;

  always_comb begin
    if (!inside3_q) begin
      st_d = lpp_pkg::ST_FRAME;
    end else if (rd_ent.exclude) begin
      st_d = lpp_pkg::ST_EXCLUDED;
    end else if (!rok3_q) begin
      st_d = lpp_pkg::ST_RANGE;
    end else begin
      st_d = lpp_pkg::ST_POINT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      st4_q  <= st_d;
      row4_q <= row3_q;
      col4_q <= col3_q;
      rng4_q <= rng3_q;
    end
  end

  // ---------------- stage 5: output register ----------------
  always_ff @(posedge clk_i) begin
    if (en5) begin
      st5_q  <= st4_q;
      row5_q <= row4_q;
      col5_q <= col4_q;
      rng5_q <= rng4_q;
    end
  end

  logic signed [lpp_pkg::POS_W-1:0] px, py, pz;

  lpp_axis u_axis_x (
    .clk_i    (clk_i),
    .mul_en_i (en4),
    .sum_en_i (en5),
    .dir_i    (rd_ent.dir_x),
    .range_i  (rng3_q),
    .off_i    (rd_ent.off_x),
    .pos_o    (px)
  );

  lpp_axis u_axis_y (
    .clk_i    (clk_i),
    .mul_en_i (en4),
    .sum_en_i (en5),
    .dir_i    (rd_ent.dir_y),
    .range_i  (rng3_q),
    .off_i    (rd_ent.off_y),
    .pos_o    (py)
  );

  lpp_axis u_axis_z (
    .clk_i    (clk_i),
    .mul_en_i (en4),
    .sum_en_i (en5),
    .dir_i    (rd_ent.dir_z),
    .range_i  (rng3_q),
    .off_i    (rd_ent.off_z),
    .pos_o    (pz)
  );

  // valid bits; loads drop out once the table is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q && (op2_q == lpp_pkg::OP_CONVERT);
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  assign status_o      = st5_q;
  assign x_pos_o       = (st5_q == lpp_pkg::ST_POINT) ? px : '0;
  assign y_pos_o       = (st5_q == lpp_pkg::ST_POINT) ? py : '0;
  assign z_pos_o       = (st5_q == lpp_pkg::ST_POINT) ? pz : '0;
  assign range_echo_o  = rng5_q;
  assign row_echo_o    = row5_q;
  assign column_echo_o = col5_q;

endmodule
`default_nettype wire
